FILE: hw/rtl/nfa_pkg.sv
package nfa_pkg;

    // Operation codes carried in the opcode field
    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_PROGRAM = 2'd1,
        OP_ERASE   = 2'd2,
        OP_FORMAT  = 2'd3
    } op_e_t;

    localparam int          ADDR_W      = 24;
    localparam int          DATA_W      = 8;
    localparam logic [7:0]  ERASED_BYTE = 8'hFF;
    localparam logic        STATUS_OK   = 1'b0;
    localparam logic        STATUS_BAD  = 1'b1;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    // Input word
    typedef struct packed {
        logic [1:0]        opcode;
        logic [ADDR_W-1:0] byte_address;
        logic [DATA_W-1:0] write_data;
        logic              last_of_transfer;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              status;
        logic              not_erased_warning;
        logic              mismatch_warning;
        logic              last_of_transfer_res;
    } out_word_t;

    // Classified command as held in the queue
    typedef struct packed {
        op_e_t             op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic              last;
        logic              bad_addr;
        logic [ADDR_W-1:0] erase_start;
    } cmd_t;

endpackage

FILE: hw/rtl/nfa_ram.sv
module nfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                           wdata,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Single port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/nfa_front.sv
module nfa_front #(
    parameter int SECTOR_BYTES = 4096,
    parameter int ARRAY_BYTES  = 65536
) (
    input  logic             in_valid,
    output logic             in_stall,
    input  nfa_pkg::in_word_t in_word,
    input  logic             q_full,
    input  logic             clear_busy,
    output logic             q_push,
    output nfa_pkg::cmd_t    q_word
);

    localparam bit SB_POW2 = ((SECTOR_BYTES & (SECTOR_BYTES - 1)) == 0);
    localparam logic [nfa_pkg::ADDR_W-1:0] SB_MASK =
        nfa_pkg::ADDR_W'(SECTOR_BYTES - 1);
    localparam logic [nfa_pkg::ADDR_W:0] LIMIT = (nfa_pkg::ADDR_W + 1)'(ARRAY_BYTES);

    // Hold off input while the queue is full or the array is being cleared
    assign in_stall = q_full | clear_busy;
    assign q_push   = in_valid & ~in_stall;

    // Classify: range check and sector start hint for erase
    always_comb
    begin
        q_word.op       = nfa_pkg::op_e_t'(in_word.opcode);
        q_word.addr     = in_word.byte_address;
        q_word.data     = in_word.write_data;
        q_word.last     = in_word.last_of_transfer;
        q_word.bad_addr = ({1'b0, in_word.byte_address} >= LIMIT);
        // power-of-two sectors: exact base; otherwise the back end searches from 0
        if (SB_POW2)
        begin
            q_word.erase_start = in_word.byte_address & ~SB_MASK;
        end
        else
        begin
            q_word.erase_start = '0;
        end
    end

endmodule

FILE: hw/rtl/nfa_queue.sv
module nfa_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  nfa_pkg::cmd_t push_word,
    output logic          full,
    input  logic          pop,
    output nfa_pkg::cmd_t head_word,
    output logic          empty
);

    nfa_pkg::cmd_t                    entry_reg [nfa_pkg::QUEUE_DEPTH];
    logic [nfa_pkg::QUEUE_PW-1:0]     wr_ptr_reg;
    logic [nfa_pkg::QUEUE_PW-1:0]     rd_ptr_reg;
    logic [nfa_pkg::QUEUE_PW:0]       count_reg;
    logic [nfa_pkg::QUEUE_PW-1:0]     wr_ptr_next;
    logic [nfa_pkg::QUEUE_PW-1:0]     rd_ptr_next;
    logic [nfa_pkg::QUEUE_PW:0]       count_next;

    assign full      = (count_reg == (nfa_pkg::QUEUE_PW + 1)'(nfa_pkg::QUEUE_DEPTH));
    assign empty     = (count_reg == '0);
    assign head_word = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == nfa_pkg::QUEUE_PW'(nfa_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == nfa_pkg::QUEUE_PW'(nfa_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

FILE: hw/rtl/nfa_back.sv
module nfa_back #(
    parameter int SECTOR_BYTES = 4096,
    parameter int SECTOR_TOTAL = 16,
    parameter int ARRAY_BYTES  = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  nfa_pkg::cmd_t      q_head,
    input  logic               q_empty,
    output logic               q_pop,
    output logic               clear_busy,
    output logic               out_valid,
    input  logic               out_stall,
    output nfa_pkg::out_word_t out_word
);

    localparam int AW  = (ARRAY_BYTES > 1) ? $clog2(ARRAY_BYTES) : 1;
    localparam int SBW = $clog2(SECTOR_BYTES + 1);
    localparam int SW  = ((AW > SBW) ? AW : SBW) + 1;

    localparam longint FMT_SPAN = longint'(SECTOR_TOTAL) * longint'(SECTOR_BYTES);
    localparam longint FMT_END  = (FMT_SPAN < longint'(ARRAY_BYTES)) ?
                                  FMT_SPAN : longint'(ARRAY_BYTES);
    localparam logic [AW-1:0] FMT_LAST   = AW'(FMT_END - 1);
    localparam logic [AW-1:0] ARRAY_LAST = AW'(ARRAY_BYTES - 1);
    localparam logic FMT_STATUS =
        ((longint'(SECTOR_TOTAL - 1) * longint'(SECTOR_BYTES)) >= longint'(ARRAY_BYTES));
    localparam logic [SW-1:0] SB_W    = SW'(SECTOR_BYTES);
    localparam logic [SW-1:0] LIMIT_W = SW'(ARRAY_BYTES);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_SEARCH,
        ST_SWEEP,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    nfa_pkg::cmd_t       cmd_reg, cmd_next;
    logic [AW-1:0]       base_reg, base_next;
    logic [AW-1:0]       sweep_reg, sweep_next;
    logic [AW-1:0]       last_reg, last_next;
    nfa_pkg::out_word_t  res_reg, res_next;
    logic                out_valid_reg, out_valid_next;
    nfa_pkg::out_word_t  out_word_reg, out_word_next;

    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [7:0]          ram_wdata;
    logic [7:0]          ram_rdata;

    logic                fin;
    nfa_pkg::out_word_t  fin_word;
    logic                out_free;
    logic [7:0]          new_byte;
    logic [SW-1:0]       sec_end;
    logic [SW-1:0]       cmd_addr_w;

    nfa_ram #(
        .WIDTH (8),
        .DEPTH (ARRAY_BYTES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign out_free   = ~out_valid_reg | ~out_stall;
    assign clear_busy = (state_reg == ST_CLEAR);
    assign new_byte   = ram_rdata & cmd_reg.data;
    assign sec_end    = SW'(base_reg) + SB_W;
    assign cmd_addr_w = SW'(cmd_reg.addr[AW-1:0]);

    // Sequencer: byte access, sector search and erase sweep
    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        base_next  = base_reg;
        sweep_next = sweep_reg;
        last_next  = last_reg;
        res_next   = res_reg;
        ram_we     = 1'b0;
        ram_addr   = sweep_reg;
        ram_wdata  = nfa_pkg::ERASED_BYTE;
        q_pop      = 1'b0;
        fin        = 1'b0;
        fin_word   = '0;

        unique case (state_reg)
            // post-reset pass: whole array to erased
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (sweep_reg == last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                ram_addr = q_head.addr[AW-1:0];
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    if (q_head.bad_addr && q_head.op != nfa_pkg::OP_FORMAT)
                    begin
                        fin                           = 1'b1;
                        fin_word.status               = nfa_pkg::STATUS_BAD;
                        fin_word.last_of_transfer_res = q_head.last;
                    end
                    else
                    begin
                        unique case (q_head.op)
                            nfa_pkg::OP_READ,
                            nfa_pkg::OP_PROGRAM:
                            begin
                                state_next = ST_ACCESS;
                            end
                            nfa_pkg::OP_ERASE:
                            begin
                                base_next  = q_head.erase_start[AW-1:0];
                                state_next = ST_SEARCH;
                            end
                            nfa_pkg::OP_FORMAT:
                            begin
                                sweep_next = '0;
                                last_next  = FMT_LAST;
                                state_next = ST_SWEEP;
                            end
                        endcase
                    end
                end
            end

            // read data is back; program writes the ANDed byte
            ST_ACCESS:
            begin
                ram_addr                      = cmd_reg.addr[AW-1:0];
                fin                           = 1'b1;
                fin_word.status               = nfa_pkg::STATUS_OK;
                fin_word.last_of_transfer_res = cmd_reg.last;
                if (cmd_reg.op == nfa_pkg::OP_PROGRAM)
                begin
                    ram_we                      = 1'b1;
                    ram_wdata                   = new_byte;
                    fin_word.read_data          = new_byte;
                    fin_word.not_erased_warning = (ram_rdata != nfa_pkg::ERASED_BYTE);
                    fin_word.mismatch_warning   = (new_byte != cmd_reg.data);
                end
                else
                begin
                    fin_word.read_data = ram_rdata;
                end
            end

            // step sector base up to the one holding the address
            ST_SEARCH:
            begin
                if (sec_end <= cmd_addr_w)
                begin
                    base_next = AW'(sec_end);
                end
                else
                begin
                    sweep_next = base_reg;
                    last_next  = (sec_end >= LIMIT_W) ? ARRAY_LAST : AW'(sec_end - 1'b1);
                    state_next = ST_SWEEP;
                end
            end

            ST_SWEEP:
            begin
                ram_we = 1'b1;
                if (sweep_reg == last_reg)
                begin
                    fin                           = 1'b1;
                    fin_word.status               = (cmd_reg.op == nfa_pkg::OP_FORMAT) ?
                                                    FMT_STATUS : nfa_pkg::STATUS_OK;
                    fin_word.last_of_transfer_res = cmd_reg.last;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end

            // result waits for the output register
            ST_DONE:
            begin
                fin      = 1'b1;
                fin_word = res_reg;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (fin)
        begin
            if (out_free)
            begin
                state_next = ST_IDLE;
            end
            else
            begin
                res_next   = fin_word;
                state_next = ST_DONE;
            end
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (fin && out_free)
        begin
            out_valid_next = 1'b1;
            out_word_next  = fin_word;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cmd_reg       <= '0;
            base_reg      <= '0;
            sweep_reg     <= '0;
            last_reg      <= ARRAY_LAST;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cmd_reg       <= cmd_next;
            base_reg      <= base_next;
            sweep_reg     <= sweep_next;
            last_reg      <= last_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_word_reg  <= out_word_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

FILE: hw/rtl/nor_flash_array_model.sv
// Channel  Valid      Stall      Word
// -------  ---------  ---------  --------------------------------
// in       in_valid   in_stall   in_word  (nfa_pkg::in_word_t)
// out      out_valid  out_stall  out_word (nfa_pkg::out_word_t)
//
// Read/program: the byte is read on the single RAM port, then a program writes it back;
// out of range is answered at dispatch. Erase: dispatch, search the sector base upward
// (exact base for power-of-two sectors), then sweep the sector bytes. Format: dispatch,
// then sweep min(SECTOR_TOTAL*SECTOR_BYTES, ARRAY_BYTES) bytes. After reset the whole
// array is swept to 0xFF; in_stall is high then. Under out_stall one finished word parks
// in the back end, the two-word queue fills, then in_stall rises.
module nor_flash_array_model #(
    parameter int SECTOR_BYTES = 4096,
    parameter int SECTOR_TOTAL = 16,
    parameter int ARRAY_BYTES  = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  nfa_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output nfa_pkg::out_word_t out_word
);

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    logic          clear_busy;
    nfa_pkg::cmd_t q_in;
    nfa_pkg::cmd_t q_head;

    nfa_front #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .ARRAY_BYTES  (ARRAY_BYTES)
    ) u_front (
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .q_full     (q_full),
        .clear_busy (clear_busy),
        .q_push     (q_push),
        .q_word     (q_in)
    );

    nfa_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .head_word (q_head),
        .empty     (q_empty)
    );

    nfa_back #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .SECTOR_TOTAL (SECTOR_TOTAL),
        .ARRAY_BYTES  (ARRAY_BYTES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_head     (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .clear_busy (clear_busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word)
    );

endmodule

FILE: tb/sv/flash_result_checker.sv
`timescale 1ns / 100ps

module flash_result_checker #(
    parameter int SECTOR_BYTES = 4096,
    parameter int SECTOR_TOTAL = 16,
    parameter int ARRAY_BYTES  = 65536
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  nfa_pkg::in_word_t  in_word,
    input  logic               out_valid,
    input  logic               out_stall,
    input  nfa_pkg::out_word_t out_word,
    output int                 mismatches,
    output int                 outstanding,
    output int                 results_checked
);

    // Shadow copy of the cell array and the words still owed by the block
    logic [7:0]         flash_image [ARRAY_BYTES];
    nfa_pkg::out_word_t pending_results [$];

    // Return one sector to the erased state, clipped at the array end
    function automatic void clear_sector(longint unsigned base);
        for (longint unsigned i = base; i < base + SECTOR_BYTES; i++)
        begin
            if (i < ARRAY_BYTES)
                flash_image[i] = nfa_pkg::ERASED_BYTE;
        end
    endfunction

    // Apply one access to the shadow array and build the word it must return
    function automatic nfa_pkg::out_word_t flash_access_result(nfa_pkg::in_word_t w);
        nfa_pkg::out_word_t r;
        logic [7:0]         old_byte;
        logic [7:0]         new_byte;
        longint unsigned    addr;
        longint unsigned    sector_base;

        r = '0;
        r.status = nfa_pkg::STATUS_OK;
        r.last_of_transfer_res = w.last_of_transfer;
        addr = w.byte_address;
        case (w.opcode)
            nfa_pkg::OP_READ:
            begin
                if (addr >= ARRAY_BYTES)
                    r.status = nfa_pkg::STATUS_BAD;
                else
                    r.read_data = flash_image[addr];
            end
            nfa_pkg::OP_PROGRAM:
            begin
                if (addr >= ARRAY_BYTES)
                    r.status = nfa_pkg::STATUS_BAD;
                else
                begin
                    // bits only go from 1 to 0
                    old_byte = flash_image[addr];
                    new_byte = old_byte & w.write_data;
                    r.not_erased_warning = (old_byte != nfa_pkg::ERASED_BYTE);
                    r.mismatch_warning   = (new_byte != w.write_data);
                    flash_image[addr]    = new_byte;
                    r.read_data          = new_byte;
                end
            end
            nfa_pkg::OP_ERASE:
            begin
                if (addr >= ARRAY_BYTES)
                    r.status = nfa_pkg::STATUS_BAD;
                else
                    clear_sector(addr - (addr % SECTOR_BYTES));
            end
            default:
            begin
                // format: every sector, skipping bases past the array
                for (int s = 0; s < SECTOR_TOTAL; s++)
                begin
                    sector_base = longint'(s) * SECTOR_BYTES;
                    if (sector_base >= ARRAY_BYTES)
                        r.status = nfa_pkg::STATUS_BAD;
                    else
                        clear_sector(sector_base);
                end
            end
        endcase
        return r;
    endfunction

    // Compare each returned word first, then queue the prediction for a new one
    always @(posedge clk or negedge rst_n)
    begin : watch_channels
        nfa_pkg::out_word_t want;
        if (!rst_n)
        begin
            foreach (flash_image[i])
                flash_image[i] = nfa_pkg::ERASED_BYTE;
            pending_results.delete();
            outstanding = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_checked++;
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected result word %h at %0t", out_word, $time);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (want.read_data !== out_word.read_data
                        || want.status !== out_word.status
                        || want.not_erased_warning !== out_word.not_erased_warning
                        || want.mismatch_warning !== out_word.mismatch_warning
                        || want.last_of_transfer_res !== out_word.last_of_transfer_res)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR at %0t: expected data %02h st %0b ne %0b ",
                                     $time, want.read_data, want.status,
                                     want.not_erased_warning,
                                     "mm %0b last %0b, ", want.mismatch_warning,
                                     want.last_of_transfer_res,
                                     "got data %02h st %0b ne %0b ",
                                     out_word.read_data, out_word.status,
                                     out_word.not_erased_warning,
                                     "mm %0b last %0b", out_word.mismatch_warning,
                                     out_word.last_of_transfer_res);
                    end
                end
            end
            if (in_valid && !in_stall)
                pending_results.push_back(flash_access_result(in_word));
            outstanding = pending_results.size();
        end
    end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;

    localparam int SECTOR_BYTES = 4096;
    localparam int SECTOR_TOTAL = 16;
    localparam int ARRAY_BYTES  = 65536;
    localparam int RANDOM_WORDS = 1600;
    localparam int QUIET_LIMIT  = 300000;
    localparam int LONG_HOLD    = 600;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    nfa_pkg::in_word_t  in_word;
    logic               out_valid;
    logic               out_stall;
    nfa_pkg::out_word_t out_word;

    int mismatches;
    int outstanding;
    int results_checked;
    int sent_words     = 0;
    int burst_left     = 0;
    int quiet_cycles   = 0;
    int format_budget  = 2;
    int erase_budget   = 30;
    int op_count [4]   = '{0, 0, 0, 0};
    bit long_hold_done = 1'b0;

    nor_flash_array_model #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .SECTOR_TOTAL (SECTOR_TOTAL),
        .ARRAY_BYTES  (ARRAY_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    flash_result_checker #(
        .SECTOR_BYTES (SECTOR_BYTES),
        .SECTOR_TOTAL (SECTOR_TOTAL),
        .ARRAY_BYTES  (ARRAY_BYTES)
    ) u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_word         (in_word),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_word        (out_word),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic nfa_pkg::in_word_t make_word(nfa_pkg::op_e_t op, logic [23:0] addr,
                                                    logic [7:0] data, logic last);
        nfa_pkg::in_word_t w;
        w.opcode           = op;
        w.byte_address     = addr;
        w.write_data       = data;
        w.last_of_transfer = last;
        return w;
    endfunction

    // Program data leaning on all-ones, all-zeros and single cleared bits
    function automatic logic [7:0] pick_data();
        case ($urandom_range(0, 9))
            0, 1:    return nfa_pkg::ERASED_BYTE;
            2, 3:    return 8'h00;
            4:       return ~(8'h01 << $urandom_range(0, 7));
            default: return 8'($urandom());
        endcase
    endfunction

    // Mostly a few hot spots per sector so cells get hit again; some near the top
    function automatic logic [23:0] pick_address();
        case ($urandom_range(0, 9))
            0:          return 24'(ARRAY_BYTES - $urandom_range(1, 6));
            1, 2, 3:    return 24'($urandom_range(0, ARRAY_BYTES - 1));
            default:    return 24'($urandom_range(0, SECTOR_TOTAL - 1) * SECTOR_BYTES
                                   + $urandom_range(0, 95));
        endcase
    endfunction

    // Drop valid for some cycles
    task automatic idle_input(int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    // Offer one word, in bursts with random gaps, and wait for it to be taken
    task automatic send_word(nfa_pkg::in_word_t w);
        if (burst_left == 0)
        begin
            idle_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20));
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_words++;
        op_count[w.opcode]++;
    endtask

    // Hold input off until every expected word has come back
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Stall pattern of the result side, with one long hold-off mid-run
    initial
    begin : receiver
        int mode;
        int span;
        int phase;
        out_stall = 1'b0;
        forever
        begin
            if (!long_hold_done && sent_words >= 700)
            begin
                long_hold_done = 1'b1;
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else
            begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 150);
                for (phase = 0; phase < span; phase++)
                begin
                    @(negedge clk);
                    case (mode)
                        0:       out_stall <= 1'b0;
                        1:       out_stall <= ($urandom_range(0, 3) == 0);
                        2:       out_stall <= ($urandom_range(0, 1) == 1);
                        default: out_stall <= (phase % 4 != 3);
                    endcase
                end
            end
        end
    end

    // Watchdog on cycles with no word moving on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL nor_flash_array_model");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int          pick;
        int          len;
        int          directed_words;
        bit          drained_mid;
        logic [23:0] base;

        drained_mid = 1'b0;
        in_valid    = 1'b0;
        in_word     = '0;
        rst_n       = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: erased read, AND programming with both warnings, range edges
        send_word(make_word(nfa_pkg::OP_READ,    24'h000000, 8'h00, 1'b1));
        send_word(make_word(nfa_pkg::OP_PROGRAM, 24'h000000, 8'hA5, 1'b0));
        send_word(make_word(nfa_pkg::OP_PROGRAM, 24'h000000, 8'h5A, 1'b1));
        send_word(make_word(nfa_pkg::OP_READ,    24'h000000, 8'hFF, 1'b0));
        send_word(make_word(nfa_pkg::OP_PROGRAM, 24'h00FFFF, 8'h00, 1'b0));
        send_word(make_word(nfa_pkg::OP_PROGRAM, 24'h00FFFF, 8'hFF, 1'b1));
        send_word(make_word(nfa_pkg::OP_READ,    24'h00FFFF, 8'h00, 1'b1));
        // first address past the array, and the very top
        send_word(make_word(nfa_pkg::OP_READ,    24'h010000, 8'h00, 1'b0));
        send_word(make_word(nfa_pkg::OP_PROGRAM, 24'hFFFFFF, 8'hFF, 1'b1));
        send_word(make_word(nfa_pkg::OP_ERASE,   24'hFFFFFF, 8'hFF, 1'b1));
        send_word(make_word(nfa_pkg::OP_ERASE,   24'h010000, 8'h00, 1'b0));
        // erase by a mid-sector address leaves neighbours alone
        send_word(make_word(nfa_pkg::OP_PROGRAM, 24'h001234, 8'h3C, 1'b0));
        send_word(make_word(nfa_pkg::OP_PROGRAM, 24'h001FFF, 8'h00, 1'b0));
        send_word(make_word(nfa_pkg::OP_PROGRAM, 24'h002000, 8'h11, 1'b1));
        send_word(make_word(nfa_pkg::OP_ERASE,   24'h001800, 8'h77, 1'b0));
        send_word(make_word(nfa_pkg::OP_READ,    24'h001234, 8'h00, 1'b0));
        send_word(make_word(nfa_pkg::OP_READ,    24'h001FFF, 8'h00, 1'b0));
        send_word(make_word(nfa_pkg::OP_READ,    24'h002000, 8'h00, 1'b0));
        send_word(make_word(nfa_pkg::OP_READ,    24'h000000, 8'h00, 1'b1));
        // format ignores its address and data
        send_word(make_word(nfa_pkg::OP_FORMAT,  24'hFFFFFF, 8'hAB, 1'b1));
        send_word(make_word(nfa_pkg::OP_READ,    24'h000000, 8'h00, 1'b0));
        send_word(make_word(nfa_pkg::OP_READ,    24'h00FFFF, 8'h00, 1'b1));
        send_word(make_word(nfa_pkg::OP_PROGRAM, 24'h00F000, 8'h0F, 1'b1));
        send_word(make_word(nfa_pkg::OP_ERASE,   24'h00FFFF, 8'h00, 1'b0));
        send_word(make_word(nfa_pkg::OP_READ,    24'h00F000, 8'h00, 1'b1));
        wait_drained();
        directed_words = sent_words;

        // Random: mostly byte transfers, some verify runs, noise, erases and formats
        while (sent_words < directed_words + RANDOM_WORDS)
        begin
            if (!drained_mid && sent_words >= directed_words + 1100)
            begin
                drained_mid = 1'b1;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            base = pick_address();
            len  = $urandom_range(1, 8);
            if (pick < 40)
            begin
                for (int i = 0; i < len; i++)
                    send_word(make_word(nfa_pkg::OP_PROGRAM, base + 24'(i), pick_data(),
                                        i == len - 1));
            end
            else if (pick < 70)
            begin
                for (int i = 0; i < len; i++)
                    send_word(make_word(nfa_pkg::OP_READ, base + 24'(i), 8'($urandom()),
                                        i == len - 1));
            end
            else if (pick < 82)
            begin
                // program a run, then read it back
                for (int i = 0; i < len; i++)
                    send_word(make_word(nfa_pkg::OP_PROGRAM, base + 24'(i), pick_data(),
                                        i == len - 1));
                for (int i = 0; i < len; i++)
                    send_word(make_word(nfa_pkg::OP_READ, base + 24'(i), 8'($urandom()),
                                        i == len - 1));
            end
            else if (pick < 95)
            begin
                // noise: any address, mostly past the array
                send_word(make_word(nfa_pkg::op_e_t'($urandom_range(0, 2)), 24'($urandom()),
                                    8'($urandom()), 1'($urandom())));
            end
            else if (pick < 99 && erase_budget > 0)
            begin
                erase_budget--;
                if ($urandom_range(0, 3) == 0)
                    base = 24'($urandom()) | 24'(ARRAY_BYTES);
                send_word(make_word(nfa_pkg::OP_ERASE, base, 8'($urandom()),
                                    1'($urandom())));
            end
            else if (pick == 99 && format_budget > 0)
            begin
                format_budget--;
                send_word(make_word(nfa_pkg::OP_FORMAT, 24'($urandom()), 8'($urandom()),
                                    1'($urandom())));
            end
            else
                send_word(make_word(nfa_pkg::OP_READ, base, 8'h00, 1'b1));
        end

        wait_drained();
        repeat (50) @(posedge clk);

        $display("Run covered %0d reads, %0d programs, %0d sector erases, %0d formats",
                 op_count[nfa_pkg::OP_READ], op_count[nfa_pkg::OP_PROGRAM],
                 op_count[nfa_pkg::OP_ERASE], op_count[nfa_pkg::OP_FORMAT]);
        $display("%0d result words checked across bursts, long output hold and drains",
                 results_checked);
        if (mismatches == 0 && outstanding == 0)
            $display("PASS nor_flash_array_model");
        else
            $display("FAIL nor_flash_array_model");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/nfa_pkg.sv
hw/rtl/nfa_ram.sv
hw/rtl/nfa_front.sv
hw/rtl/nfa_queue.sv
hw/rtl/nfa_back.sv
hw/rtl/nor_flash_array_model.sv
tb/sv/flash_result_checker.sv
tb/sv/tb.sv
